// ===== hdl/vdh_pkg.sv =====
// ----------------------------------------------------------------------------
// vdh_pkg - shared constants for the vector direction to hue color block
// Angle format, arctangent table of the vectoring pipeline and the codes of
// the six hue wheel sectors.
// ----------------------------------------------------------------------------
package vdh_pkg;

	// Angle accumulator: unsigned fraction of a full turn, wrapping
	localparam int ANG_BITS = 32;

	// Deepest vectoring pipeline that the arctangent table supports
	localparam int MAX_ITERATIONS = 24;
	localparam int ITER_IDX_BITS  = 5;

	// Hue wheel sector codes (hue * 6, integer part)
	localparam int SECTOR_BITS = 3;
	localparam logic [SECTOR_BITS-1:0] SEC_RED_YELLOW   = 3'd0;
	localparam logic [SECTOR_BITS-1:0] SEC_YELLOW_GREEN = 3'd1;
	localparam logic [SECTOR_BITS-1:0] SEC_GREEN_CYAN   = 3'd2;
	localparam logic [SECTOR_BITS-1:0] SEC_CYAN_BLUE    = 3'd3;
	localparam logic [SECTOR_BITS-1:0] SEC_BLUE_MAGENTA = 3'd4;
	localparam logic [SECTOR_BITS-1:0] SEC_MAGENTA_RED  = 3'd5;

	// atan(2^-i) / (2*pi) * 2^32
	function automatic logic [ANG_BITS-1:0] atan_turn(input logic [ITER_IDX_BITS-1:0] idx);
		logic [ANG_BITS-1:0] val;
		val = '0;
		case (idx)
			5'd0:    val = 32'h2000_0000;
			5'd1:    val = 32'h12E4_051E;
			5'd2:    val = 32'h09FB_385B;
			5'd3:    val = 32'h0511_11D4;
			5'd4:    val = 32'h028B_0D43;
			5'd5:    val = 32'h0145_D7E1;
			5'd6:    val = 32'h00A2_F61E;
			5'd7:    val = 32'h0051_7C55;
			5'd8:    val = 32'h0028_BE53;
			5'd9:    val = 32'h0014_5F2F;
			5'd10:   val = 32'h000A_2F98;
			5'd11:   val = 32'h0005_17CC;
			5'd12:   val = 32'h0002_8BE6;
			5'd13:   val = 32'h0001_45F3;
			5'd14:   val = 32'h0000_A2F9;
			5'd15:   val = 32'h0000_517C;
			5'd16:   val = 32'h0000_28BE;
			5'd17:   val = 32'h0000_145F;
			5'd18:   val = 32'h0000_0A2F;
			5'd19:   val = 32'h0000_0517;
			5'd20:   val = 32'h0000_028B;
			5'd21:   val = 32'h0000_0145;
			5'd22:   val = 32'h0000_00A2;
			5'd23:   val = 32'h0000_0051;
			default: val = '0;
		endcase
		return val;
	endfunction

endpackage

// ===== hdl/vector_direction_to_hue_color_top.sv =====
// ----------------------------------------------------------------------------
// vector_direction_to_hue_color_top - vector direction to hue wheel color
// Finds the direction of a signed 2D vector with a pipelined CORDIC
// vectoring unit, rounds it to a hue fraction of a full turn and colors it
// with the six-sector HSV wheel at full saturation and value.
// ----------------------------------------------------------------------------
//
//  Channel  Signals                          Dir  Notes
//  -------  -------------------------------  ---  ---------------------------
//  in       in_valid in_ready vec_x vec_y    in   one vector per item
//  out      out_valid out_ready hue red      out  one color per item
//           green blue
//
// One item enters per cycle while the output is not stalled. The pipeline has
// one capture and pre-rotation stage, one CORDIC stage per iteration, then hue
// rounding, sector split and ramp level stages.
// Reset clears only the valid bits of the stages.
// When the output register is full and not taken, the whole pipeline holds;
// in_ready drops in that cycle, so no item is lost or repeated.
// ----------------------------------------------------------------------------
module vector_direction_to_hue_color_top #(
	parameter int COMPONENT_BITS   = 16,
	parameter int HUE_BITS         = 16,
	parameter int COLOR_BITS       = 8,
	parameter int ANGLE_ITERATIONS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic signed [COMPONENT_BITS-1:0] vec_x,
	input  logic signed [COMPONENT_BITS-1:0] vec_y,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic        [HUE_BITS-1:0]       hue,
	output logic        [COLOR_BITS-1:0]     red,
	output logic        [COLOR_BITS-1:0]     green,
	output logic        [COLOR_BITS-1:0]     blue
);
	import vdh_pkg::*;

	// Components carry 2^ITER of scaling, one bit for the negated minimum
	// and one for CORDIC gain
	localparam int W    = COMPONENT_BITS + ANGLE_ITERATIONS + 2;
	localparam int IT   = ANGLE_ITERATIONS;
	localparam int PW   = HUE_BITS + 1 + COLOR_BITS;
	localparam logic [ANG_BITS:0] HUE_HALF =
		(ANG_BITS + 1)'(1) << (ANG_BITS - 1 - HUE_BITS);
	localparam logic [HUE_BITS:0]   HUE_ONE  = (HUE_BITS + 1)'(1) << HUE_BITS;
	localparam logic [PW-1:0]       LVL_HALF = PW'(1) << (HUE_BITS - 1);
	localparam logic [COLOR_BITS-1:0] FULL   = {COLOR_BITS{1'b1}};

	logic en;

	// CORDIC stage registers: index 0 is the capture stage
	logic signed [W-1:0]        cx_s [0:IT];
	logic signed [W-1:0]        cy_s [0:IT];
	logic        [ANG_BITS-1:0] ca_s [0:IT];
	logic                       cz_s [0:IT];
	logic                       cv_s [0:IT];

	// Post stages: hue rounding (sh), sector split (sc), output (so)
	logic                   v_sh, v_sc, v_so;
	logic [HUE_BITS-1:0]    hue_sh, hue_sc;
	logic [SECTOR_BITS-1:0] sec_sc;
	logic [HUE_BITS:0]      lvl_sc;

	// Advance everything unless the output holds an item not yet taken
	assign en       = !v_so || out_ready;
	assign in_ready = en;

	// Pre-rotate into the right half plane
	logic signed [W-1:0] xe, ye;
	logic                xneg;
	always_comb begin
		xe   = W'(vec_x) <<< IT;
		ye   = W'(vec_y) <<< IT;
		xneg = vec_x[COMPONENT_BITS-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cv_s[0] <= 1'b0;
		end else if (en) begin
			cv_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s[0] <= xneg ? -xe : xe;
			cy_s[0] <= xneg ? -ye : ye;
			ca_s[0] <= xneg ? {1'b1, {(ANG_BITS-1){1'b0}}} : '0;
			cz_s[0] <= (vec_x == '0) && (vec_y == '0);
		end
	end

	// One micro-rotation per stage, driving y toward zero
	for (genvar i = 0; i < IT; i++) begin : g_cordic
		logic signed [W-1:0] dx, dy;
		logic                up;
		always_comb begin
			dx = cy_s[i] >>> i;
			dy = cx_s[i] >>> i;
			up = !cy_s[i][W-1] && (cy_s[i] != '0);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cv_s[i+1] <= 1'b0;
			end else if (en) begin
				cv_s[i+1] <= cv_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				cx_s[i+1] <= up ? cx_s[i] + dx : cx_s[i] - dx;
				cy_s[i+1] <= up ? cy_s[i] - dy : cy_s[i] + dy;
				ca_s[i+1] <= up ? ca_s[i] + atan_turn(ITER_IDX_BITS'(i))
				                : ca_s[i] - atan_turn(ITER_IDX_BITS'(i));
				cz_s[i+1] <= cz_s[i];
			end
		end
	end

	// Round the angle half-up to the hue width; a full turn wraps to zero
	logic [ANG_BITS:0] rsum;
	assign rsum = {1'b0, ca_s[IT]} + HUE_HALF;

	// Split hue * 6 into sector and ramp level
	logic [HUE_BITS+2:0]    h6;
	logic [HUE_BITS-1:0]    frac;
	logic [SECTOR_BITS-1:0] sec;
	always_comb begin
		h6   = ((HUE_BITS + 3)'(hue_sh) << 2) + ((HUE_BITS + 3)'(hue_sh) << 1);
		sec  = h6[HUE_BITS +: SECTOR_BITS];
		frac = h6[HUE_BITS-1:0];
	end

	// Scale the ramp level to the color range, rounded
	logic [PW-1:0]         lvl_sum;
	logic [COLOR_BITS-1:0] lv;
	always_comb begin
		lvl_sum = PW'(lvl_sc) * PW'(FULL) + LVL_HALF;
		lv      = lvl_sum[HUE_BITS +: COLOR_BITS];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sh <= 1'b0;
			v_sc <= 1'b0;
			v_so <= 1'b0;
		end else if (en) begin
			v_sh <= cv_s[IT];
			v_sc <= v_sh;
			v_so <= v_sc;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hue_sh <= cz_s[IT] ? '0 : rsum[ANG_BITS-HUE_BITS +: HUE_BITS];

			hue_sc <= hue_sh;
			sec_sc <= sec;
			lvl_sc <= sec[0] ? HUE_ONE - {1'b0, frac} : {1'b0, frac};

			hue <= hue_sc;
			unique case (sec_sc)
				SEC_YELLOW_GREEN: begin red <= lv;   green <= FULL; blue <= '0;   end
				SEC_GREEN_CYAN:   begin red <= '0;   green <= FULL; blue <= lv;   end
				SEC_CYAN_BLUE:    begin red <= '0;   green <= lv;   blue <= FULL; end
				SEC_BLUE_MAGENTA: begin red <= lv;   green <= '0;   blue <= FULL; end
				SEC_MAGENTA_RED:  begin red <= FULL; green <= '0;   blue <= lv;   end
				default:          begin red <= FULL; green <= lv;   blue <= '0;   end
			endcase
		end
	end

	assign out_valid = v_so;

	// A stalled output must block intake in the same cycle
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !in_ready)
		else $error("item accepted while output stalled");

	// A new output item comes from a valid sector stage
	a_out_from_sc: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !$past(out_valid)) |-> $past(v_sc))
		else $error("output valid without a preceding item");

	// Every wheel color has one channel full and one channel off
	a_wheel_color: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((red == FULL || green == FULL || blue == FULL) &&
		               (red == '0 || green == '0 || blue == '0)))
		else $error("output color is off the hue wheel");

endmodule

// ===== bench/vector_direction_to_hue_color_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_direction_to_hue_color_checker - result checker for the hue coder
// Watches both channels of the block. For every vector taken in, it computes
// the direction angle with its own CORDIC, rounds it to a hue and colors it
// on the six-sector wheel. It then compares each color that leaves the block
// with the oldest expected one, field by field.
// ----------------------------------------------------------------------------
module vector_direction_to_hue_color_checker #(
	parameter int COMPONENT_BITS   = 16,
	parameter int HUE_BITS         = 16,
	parameter int COLOR_BITS       = 8,
	parameter int ANGLE_ITERATIONS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic                             in_ready,
	input  logic signed [COMPONENT_BITS-1:0] vec_x,
	input  logic signed [COMPONENT_BITS-1:0] vec_y,
	input  logic                             out_valid,
	input  logic                             out_ready,
	input  logic        [HUE_BITS-1:0]       hue,
	input  logic        [COLOR_BITS-1:0]     red,
	input  logic        [COLOR_BITS-1:0]     green,
	input  logic        [COLOR_BITS-1:0]     blue,
	output int                               errors,
	output int                               pending
);
	import vdh_pkg::*;

	typedef struct packed {
		logic [HUE_BITS-1:0]   hue;
		logic [COLOR_BITS-1:0] red;
		logic [COLOR_BITS-1:0] green;
		logic [COLOR_BITS-1:0] blue;
	} wheel_color_t;

	localparam int TURN_TAB_SIZE = MAX_ITERATIONS;

	// Arctangent of 2^-i as a fraction of a full turn, 2^-32 units
	localparam logic [ANG_BITS-1:0] ARCTAN_TURNS [0:TURN_TAB_SIZE-1] = '{
		32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
		32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
		32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
		32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2F9, 32'h0000_517C,
		32'h0000_28BE, 32'h0000_145F, 32'h0000_0A2F, 32'h0000_0517,
		32'h0000_028B, 32'h0000_0145, 32'h0000_00A2, 32'h0000_0051
	};

	wheel_color_t expected_colors [$];

	// Direction of the vector, rounded to a hue, then colored on the wheel
	function automatic wheel_color_t color_of_vector(
		input logic signed [COMPONENT_BITS-1:0] vx,
		input logic signed [COMPONENT_BITS-1:0] vy
	);
		wheel_color_t          c;
		longint                px;
		longint                py;
		longint                shx;
		longint                shy;
		logic [ANG_BITS-1:0]   turns;
		longint unsigned       rounded;
		longint unsigned       h6;
		longint unsigned       frac;
		longint unsigned       level;
		longint unsigned       ramp;
		longint unsigned       full;
		logic [SECTOR_BITS-1:0] sec;
		int                    steps;
		int                    i;

		rounded = 0;
		if (vx != 0 || vy != 0) begin
			px = longint'(vx) * (longint'(1) << ANGLE_ITERATIONS);
			py = longint'(vy) * (longint'(1) << ANGLE_ITERATIONS);
			turns = '0;
			// fold the left half plane onto the right one
			if (px < 0) begin
				px = -px;
				py = -py;
				turns = 32'h8000_0000;
			end
			steps = (ANGLE_ITERATIONS > TURN_TAB_SIZE) ? TURN_TAB_SIZE : ANGLE_ITERATIONS;
			// rotate the vector onto the +x axis, summing the angles taken
			for (i = 0; i < steps; i++) begin
				shx = py >>> i;
				shy = px >>> i;
				if (py > 0) begin
					px = px + shx;
					py = py - shy;
					turns = turns + ARCTAN_TURNS[i];
				end else begin
					px = px - shx;
					py = py + shy;
					turns = turns - ARCTAN_TURNS[i];
				end
			end
			rounded = ({32'd0, turns} + (64'd1 << (31 - HUE_BITS))) >> (32 - HUE_BITS);
		end
		c.hue = rounded[HUE_BITS-1:0];

		// split hue * 6 into sector and ramp position
		h6    = 64'(c.hue) * 64'd6;
		sec   = SECTOR_BITS'(h6 >> HUE_BITS);
		frac  = h6 & ((64'd1 << HUE_BITS) - 64'd1);
		level = sec[0] ? ((64'd1 << HUE_BITS) - frac) : frac;
		full  = (64'd1 << COLOR_BITS) - 64'd1;
		ramp  = (level * full + (64'd1 << (HUE_BITS - 1))) >> HUE_BITS;

		case (sec)
			SEC_YELLOW_GREEN: begin
				c.red = ramp[COLOR_BITS-1:0]; c.green = full[COLOR_BITS-1:0]; c.blue = '0;
			end
			SEC_GREEN_CYAN: begin
				c.red = '0; c.green = full[COLOR_BITS-1:0]; c.blue = ramp[COLOR_BITS-1:0];
			end
			SEC_CYAN_BLUE: begin
				c.red = '0; c.green = ramp[COLOR_BITS-1:0]; c.blue = full[COLOR_BITS-1:0];
			end
			SEC_BLUE_MAGENTA: begin
				c.red = ramp[COLOR_BITS-1:0]; c.green = '0; c.blue = full[COLOR_BITS-1:0];
			end
			SEC_MAGENTA_RED: begin
				c.red = full[COLOR_BITS-1:0]; c.green = '0; c.blue = ramp[COLOR_BITS-1:0];
			end
			default: begin
				c.red = full[COLOR_BITS-1:0]; c.green = ramp[COLOR_BITS-1:0]; c.blue = '0;
			end
		endcase
		return c;
	endfunction

	// Check leaving colors first, then queue the prediction for a new vector
	always @(posedge clk or negedge arst_n) begin
		wheel_color_t want;
		if (!arst_n) begin
			expected_colors.delete();
			errors  <= 0;
			pending <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_colors.size() == 0) begin
					$error("color item with no vector waiting: hue %0d rgb %0d %0d %0d",
						hue, red, green, blue);
					errors <= errors + 1;
				end else begin
					want = expected_colors.pop_front();
					if (hue !== want.hue)
						$error("hue: expected %0d, actual %0d", want.hue, hue);
					if (red !== want.red)
						$error("red: expected %0d, actual %0d", want.red, red);
					if (green !== want.green)
						$error("green: expected %0d, actual %0d", want.green, green);
					if (blue !== want.blue)
						$error("blue: expected %0d, actual %0d", want.blue, blue);
					if (hue !== want.hue || red !== want.red || green !== want.green ||
						blue !== want.blue)
						errors <= errors + 1;
				end
			end
			if (in_valid && in_ready)
				expected_colors.push_back(color_of_vector(vec_x, vec_y));
			pending <= expected_colors.size();
		end
	end

endmodule

// ===== bench/vector_direction_to_hue_color_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_direction_to_hue_color_top_tb - testbench of the hue coder
// Drives vectors in bursts with random gaps while the color side stalls on
// its own pattern: first the extreme and special vectors, then random ones
// of several shapes. One long color stall fills the pipeline, and one pause
// drains it. The checker beside the block predicts and compares every item.
// ----------------------------------------------------------------------------
module vector_direction_to_hue_color_top_tb;

	localparam int COMPONENT_BITS   = 16;
	localparam int HUE_BITS         = 16;
	localparam int COLOR_BITS       = 8;
	localparam int ANGLE_ITERATIONS = 16;

	localparam int RANDOM_ITEMS  = 1800;
	localparam int LONG_HOLD     = 400;
	localparam int IDLE_LIMIT    = 5000;
	localparam int TAIL_CYCLES   = ANGLE_ITERATIONS + 12;
	localparam int HOLD_AT_ITEM  = 600;
	localparam int DRAIN_AT_ITEM = 1200;

	// receiver stall patterns
	localparam int RX_ALWAYS = 0;
	localparam int RX_COIN   = 1;
	localparam int RX_SPARSE = 2;
	localparam int RX_BUSY   = 3;

	localparam logic signed [COMPONENT_BITS-1:0] CMAX = 16'sh7FFF;
	localparam logic signed [COMPONENT_BITS-1:0] CMIN = 16'sh8000;

	logic                             clk;
	logic                             arst_n;
	logic                             in_valid;
	logic                             in_ready;
	logic signed [COMPONENT_BITS-1:0] vec_x;
	logic signed [COMPONENT_BITS-1:0] vec_y;
	logic                             out_valid;
	logic                             out_ready;
	logic        [HUE_BITS-1:0]       hue;
	logic        [COLOR_BITS-1:0]     red;
	logic        [COLOR_BITS-1:0]     green;
	logic        [COLOR_BITS-1:0]     blue;

	int errors;
	int pending;
	int burst_left;
	int gapless_left;
	int idle_cycles;
	bit hold_req;

	vector_direction_to_hue_color_top #(
		.COMPONENT_BITS  (COMPONENT_BITS),
		.HUE_BITS        (HUE_BITS),
		.COLOR_BITS      (COLOR_BITS),
		.ANGLE_ITERATIONS(ANGLE_ITERATIONS)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.vec_x    (vec_x),
		.vec_y    (vec_y),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.hue      (hue),
		.red      (red),
		.green    (green),
		.blue     (blue)
	);

	vector_direction_to_hue_color_checker #(
		.COMPONENT_BITS  (COMPONENT_BITS),
		.HUE_BITS        (HUE_BITS),
		.COLOR_BITS      (COLOR_BITS),
		.ANGLE_ITERATIONS(ANGLE_ITERATIONS)
	) u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.vec_x    (vec_x),
		.vec_y    (vec_y),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.hue      (hue),
		.red      (red),
		.green    (green),
		.blue     (blue),
		.errors   (errors),
		.pending  (pending)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// One of the component values at the edges of the range
	function automatic logic signed [COMPONENT_BITS-1:0] edge_component();
		case ($urandom_range(0, 6))
			0:       return CMIN;
			1:       return CMIN + 1;
			2:       return -1;
			3:       return 0;
			4:       return 1;
			5:       return CMAX - 1;
			default: return CMAX;
		endcase
	endfunction

	// Present one vector, opening a new burst after a random gap when due
	task automatic send_vector(input logic signed [COMPONENT_BITS-1:0] x,
		input logic signed [COMPONENT_BITS-1:0] y);
		int gap;
		if (gapless_left > 0) begin
			gapless_left--;
		end else if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200)
				: $urandom_range(1, 16);
		end else begin
			burst_left--;
		end
		in_valid <= 1'b1;
		vec_x    <= x;
		vec_y    <= y;
		do @(posedge clk); while (!in_ready);
	endtask

	// Stop offering and wait until every color has come out
	task automatic drain_colors();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// Receiver: random stall patterns, plus one long hold on request
	initial begin : rx_pattern
		int mode;
		int run;
		int hold_left;
		mode      = RX_ALWAYS;
		run       = 0;
		hold_left = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = LONG_HOLD - 1;
				out_ready <= 1'b0;
			end else begin
				if (run == 0) begin
					mode = $urandom_range(RX_ALWAYS, RX_BUSY);
					run  = $urandom_range(5, 120);
				end
				run--;
				case (mode)
					RX_COIN:   out_ready <= ($urandom_range(0, 1) == 1);
					RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
					RX_BUSY:   out_ready <= ($urandom_range(0, 7) != 0);
					default:   out_ready <= 1'b1;
				endcase
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("vector_direction_to_hue_color_top_tb failed");
			$finish;
		end
	end

	// Stimulus and verdict
	initial begin : stimulus
		logic signed [COMPONENT_BITS-1:0] x;
		logic signed [COMPONENT_BITS-1:0] y;
		int n;
		int mag;

		arst_n       = 1'b0;
		in_valid     <= 1'b0;
		vec_x        <= '0;
		vec_y        <= '0;
		hold_req     = 1'b0;
		burst_left   = 0;
		gapless_left = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero vector, axes, extreme corners
		send_vector(0, 0);
		send_vector(CMAX, 0);
		send_vector(CMIN, 0);
		send_vector(0, CMAX);
		send_vector(0, CMIN);
		send_vector(1, 0);
		send_vector(-1, 0);
		send_vector(0, 1);
		send_vector(0, -1);
		send_vector(CMAX, CMAX);
		send_vector(CMIN, CMIN);
		send_vector(CMAX, CMIN);
		send_vector(CMIN, CMAX);
		send_vector(-1, -1);
		// just below a full turn: may wrap to hue zero
		send_vector(CMAX, -1);
		send_vector(1, -1);
		send_vector(CMAX, -2);
		send_vector(20000, -3);
		// near the sector boundaries at 60, 120, 240 and 300 degrees
		send_vector(10000, 17321);
		send_vector(-10000, 17320);
		send_vector(-10000, -17321);
		send_vector(10000, -17320);
		send_vector(CMIN, -1);
		send_vector(CMIN, 1);

		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == HOLD_AT_ITEM) begin
				// long color stall while vectors keep coming
				hold_req     = 1'b1;
				gapless_left = 150;
			end
			if (n == DRAIN_AT_ITEM)
				drain_colors();
			case ($urandom_range(0, 9))
				4: begin
					x = COMPONENT_BITS'($urandom_range(0, 16) - 8);
					y = COMPONENT_BITS'($urandom_range(0, 16) - 8);
				end
				5: begin
					x = COMPONENT_BITS'(CMAX - $urandom_range(0, 20000));
					y = COMPONENT_BITS'($urandom_range(0, 6) - 3);
				end
				6: begin
					if ($urandom_range(0, 1) == 1) begin
						x = COMPONENT_BITS'($urandom());
						y = 0;
					end else begin
						x = 0;
						y = COMPONENT_BITS'($urandom());
					end
				end
				7: begin
					// near a 60 degree line, random quadrant
					mag = $urandom_range(1, 18000);
					x   = COMPONENT_BITS'(mag);
					y   = COMPONENT_BITS'((mag * 1774) >>> 10);
					if ($urandom_range(0, 1) == 1) x = -x;
					if ($urandom_range(0, 1) == 1) y = -y;
				end
				8: begin
					x = edge_component();
					y = edge_component();
				end
				9: begin
					x = COMPONENT_BITS'(CMIN + $urandom_range(0, 20000));
					y = COMPONENT_BITS'($urandom_range(0, 6) - 3);
				end
				default: begin
					x = COMPONENT_BITS'($urandom());
					y = COMPONENT_BITS'($urandom());
				end
			endcase
			send_vector(x, y);
		end

		drain_colors();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("vector_direction_to_hue_color_top_tb passed");
		else
			$display("vector_direction_to_hue_color_top_tb failed");
		$finish;
	end

endmodule

// ===== vector_direction_to_hue_color_top.f =====
hdl/vdh_pkg.sv
hdl/vector_direction_to_hue_color_top.sv
bench/vector_direction_to_hue_color_checker.sv
bench/vector_direction_to_hue_color_top_tb.sv
